FILE: sv/lfsf_pkg.sv
// ----------------------------------------------------------------------------
// lfsf_pkg
// Shared widths, register indexes and stage control type for the
// largest free square finder.
// ----------------------------------------------------------------------------
package lfsf_pkg;

	localparam int CFG_W           = 11;
	localparam int CFG_IDX_W       = 1;
	localparam int SIZE_W          = 11;
	localparam int POS_W           = 10;
	localparam int MAX_COLUMNS_DEF = 1024;
	localparam int MAX_ROWS_DEF    = 1024;
	localparam logic [CFG_W-1:0] COUNT_RESET = 11'd1024;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd1;

	// per-cell flags carried from acceptance into the size stage
	typedef struct packed {
		logic free;
		logic first_row;
		logic first_col;
		logic row_end;
		logic map_end;
	} cell_ctl_t;

endpackage

FILE: sv/largest_free_square_finder.sv
// ----------------------------------------------------------------------------
// largest_free_square_finder
// Maximal free square over a map streamed in row-major order, one cell per
// transfer; one result per map.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir | transfer
//  --------+-------------------------------------------+-----+-----------------
//  in      | in_valid, in_ready, cell_free             | in  | valid & ready
//  out     | out_valid, out_ready, square_size,        | out | valid & ready
//          | top_row, left_column                      |     |
//  cfg     | cfg_write_en, cfg_index, cfg_data         | in  | write enable
//
// One cell per cycle sustained while no result stalls the input; the line
// buffer read starts at the cell's transfer, and the size stage then writes
// the size back and updates the best. One read per cell sets the rate.
// Reset clears counters and control; the line buffer needs no clearing pass.
// A result waiting in the output register holds the last cell of the next
// map in the size stage and stalls the input behind it.
// ----------------------------------------------------------------------------
module largest_free_square_finder #(
	parameter int MAX_COLUMNS = lfsf_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = lfsf_pkg::MAX_ROWS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cell_free,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [lfsf_pkg::SIZE_W-1:0]    square_size,
	output logic [lfsf_pkg::POS_W-1:0]     top_row,
	output logic [lfsf_pkg::POS_W-1:0]     left_column,
	input  logic                           cfg_write_en,
	input  logic [lfsf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lfsf_pkg::CFG_W-1:0]     cfg_data
);

	localparam int CFG_W     = lfsf_pkg::CFG_W;
	localparam int SW        = lfsf_pkg::SIZE_W;
	localparam int COL_W     = $clog2(MAX_COLUMNS);
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_CNT_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
	localparam int ROW_CNT_W = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

	logic [CFG_W-1:0]     row_count_q;
	logic [CFG_W-1:0]     column_count_q;
	logic [ROW_W-1:0]     row_index_q;
	logic [COL_W-1:0]     column_index_q;
	logic [COL_CNT_W-1:0] col_cfg;
	logic [COL_CNT_W-1:0] cols_eff;
	logic [COL_CNT_W-1:0] col_next;
	logic [ROW_CNT_W-1:0] row_cfg;
	logic [ROW_CNT_W-1:0] rows_eff;
	logic [ROW_CNT_W-1:0] row_next;
	logic                 row_end;
	logic                 map_end;
	logic                 accept;
	logic                 s1_hold;
	logic                 s1_adv;
	logic                 fwd_hit;
	logic                 s1_valid_q;
	lfsf_pkg::cell_ctl_t  ctl_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [COL_W-1:0]     col_s1;
	logic [SW-1:0]        up_raw;
	logic [SW-1:0]        size;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= lfsf_pkg::COUNT_RESET;
			column_count_q <= lfsf_pkg::COUNT_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				lfsf_pkg::CFG_ROW_COUNT:    row_count_q    <= cfg_data;
				lfsf_pkg::CFG_COLUMN_COUNT: column_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp counts: zero means one, above the maximum means the maximum
	always_comb begin
		col_cfg = COL_CNT_W'(column_count_q);
		if (col_cfg == '0) begin
			cols_eff = COL_CNT_W'(1);
		end else if (col_cfg > COL_CNT_W'(MAX_COLUMNS)) begin
			cols_eff = COL_CNT_W'(MAX_COLUMNS);
		end else begin
			cols_eff = col_cfg;
		end
		row_cfg = ROW_CNT_W'(row_count_q);
		if (row_cfg == '0) begin
			rows_eff = ROW_CNT_W'(1);
		end else if (row_cfg > ROW_CNT_W'(MAX_ROWS)) begin
			rows_eff = ROW_CNT_W'(MAX_ROWS);
		end else begin
			rows_eff = row_cfg;
		end
		col_next = COL_CNT_W'(column_index_q) + COL_CNT_W'(1);
		row_next = ROW_CNT_W'(row_index_q) + ROW_CNT_W'(1);
		row_end  = !(col_next < cols_eff);
		map_end  = row_end && !(row_next < rows_eff);
	end

	assign s1_hold  = s1_valid_q && ctl_s1.map_end && out_valid && !out_ready;
	assign s1_adv   = s1_valid_q && !s1_hold;
	assign in_ready = !s1_valid_q || !s1_hold;
	assign accept   = in_valid && in_ready;
	assign fwd_hit  = s1_valid_q && (col_s1 == column_index_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_index_q    <= '0;
			column_index_q <= '0;
			s1_valid_q     <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				if (!row_end) begin
					column_index_q <= COL_W'(col_next);
				end else if (!map_end) begin
					row_index_q    <= ROW_W'(row_next);
					column_index_q <= '0;
				end else begin
					row_index_q    <= '0;
					column_index_q <= '0;
				end
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.free      <= cell_free;
			ctl_s1.first_row <= (row_index_q == '0);
			ctl_s1.first_col <= (column_index_q == '0);
			ctl_s1.row_end   <= row_end;
			ctl_s1.map_end   <= map_end;
			row_s1           <= row_index_q;
			col_s1           <= column_index_q;
		end
	end

	lfsf_line_buf #(
		.DEPTH  (MAX_COLUMNS),
		.ADDR_W (COL_W),
		.DATA_W (SW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (column_index_q),
		.rd_data (up_raw),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (size)
	);

	lfsf_sizer u_sizer (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.advance (s1_adv),
		.fwd_hit (fwd_hit),
		.ctl     (ctl_s1),
		.up_raw  (up_raw),
		.size    (size)
	);

	lfsf_tracker #(
		.ROW_W (ROW_W),
		.COL_W (COL_W)
	) u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (s1_adv),
		.map_end     (ctl_s1.map_end),
		.size        (size),
		.row         (row_s1),
		.col         (col_s1),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.square_size (square_size),
		.top_row     (top_row),
		.left_column (left_column)
	);

endmodule

FILE: sv/lfsf_line_buf.sv
// ----------------------------------------------------------------------------
// lfsf_line_buf
// Previous-row size memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfsf_line_buf #(
	parameter int DEPTH  = lfsf_pkg::MAX_COLUMNS_DEF,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = lfsf_pkg::SIZE_W
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/lfsf_sizer.sv
// ----------------------------------------------------------------------------
// lfsf_sizer
// Square size of the cell in the size stage, with left and upper-left
// history and write-to-read forwarding for the line buffer.
// ----------------------------------------------------------------------------
module lfsf_sizer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        advance,
	input  logic                        fwd_hit,
	input  lfsf_pkg::cell_ctl_t         ctl,
	input  logic [lfsf_pkg::SIZE_W-1:0] up_raw,
	output logic [lfsf_pkg::SIZE_W-1:0] size
);

	localparam int SW = lfsf_pkg::SIZE_W;

	logic [SW-1:0] left_q;
	logic [SW-1:0] corner_q;
	logic          fwd_q;
	logic [SW-1:0] fwd_data_q;
	logic [SW-1:0] up;
	logic [SW-1:0] min_lc;
	logic [SW-1:0] min_all;

	always_comb begin
		if (ctl.first_row) begin
			up = '0;
		end else if (fwd_q) begin
			up = fwd_data_q;
		end else begin
			up = up_raw;
		end
		min_lc  = (left_q < corner_q) ? left_q : corner_q;
		min_all = (up < min_lc) ? up : min_lc;
		if (!ctl.free) begin
			size = '0;
		end else if (ctl.first_row || ctl.first_col) begin
			size = SW'(1);
		end else begin
			size = min_all + SW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			corner_q <= '0;
			fwd_q    <= 1'b0;
		end else begin
			if (advance) begin
				// clear the history at each row end
				left_q   <= ctl.row_end ? '0 : size;
				corner_q <= ctl.row_end ? '0 : up;
			end
			if (accept) begin
				fwd_q <= fwd_hit;
			end
		end
	end

	// the line buffer read for the next cell misses a write of this cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_data_q <= size;
		end
	end

endmodule

FILE: sv/lfsf_tracker.sv
// ----------------------------------------------------------------------------
// lfsf_tracker
// Largest size so far and its bottom-right cell; result register holding
// the size and top-left corner at the end of a map.
// ----------------------------------------------------------------------------
module lfsf_tracker #(
	parameter int ROW_W = 10,
	parameter int COL_W = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        map_end,
	input  logic [lfsf_pkg::SIZE_W-1:0] size,
	input  logic [ROW_W-1:0]            row,
	input  logic [COL_W-1:0]            col,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [lfsf_pkg::SIZE_W-1:0] square_size,
	output logic [lfsf_pkg::POS_W-1:0]  top_row,
	output logic [lfsf_pkg::POS_W-1:0]  left_column
);

	localparam int SW  = lfsf_pkg::SIZE_W;
	localparam int PW  = lfsf_pkg::POS_W;
	localparam int RXW = (ROW_W > SW) ? ROW_W : SW;
	localparam int CXW = (COL_W > SW) ? COL_W : SW;

	logic [SW-1:0]    best_size_q;
	logic [ROW_W-1:0] best_row_q;
	logic [COL_W-1:0] best_col_q;
	logic [SW-1:0]    nxt_size;
	logic [ROW_W-1:0] nxt_row;
	logic [COL_W-1:0] nxt_col;
	logic [RXW-1:0]   top_full;
	logic [CXW-1:0]   left_full;

	always_comb begin
		if (size > best_size_q) begin
			nxt_size = size;
			nxt_row  = row;
			nxt_col  = col;
		end else begin
			nxt_size = best_size_q;
			nxt_row  = best_row_q;
			nxt_col  = best_col_q;
		end
		if (nxt_size != '0) begin
			top_full  = RXW'(nxt_row) - (RXW'(nxt_size) - RXW'(1));
			left_full = CXW'(nxt_col) - (CXW'(nxt_size) - CXW'(1));
		end else begin
			top_full  = '0;
			left_full = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (advance) begin
				if (map_end) begin
					best_size_q <= '0;
					best_row_q  <= '0;
					best_col_q  <= '0;
				end else begin
					best_size_q <= nxt_size;
					best_row_q  <= nxt_row;
					best_col_q  <= nxt_col;
				end
			end
			if (advance && map_end) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && map_end) begin
			square_size <= nxt_size;
			top_row     <= top_full[PW-1:0];
			left_column <= left_full[PW-1:0];
		end
	end

endmodule

FILE: sv/lfsf_checker.sv
// ----------------------------------------------------------------------------
// lfsf_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lfsf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [lfsf_pkg::SIZE_W-1:0] square_size,
	input logic [lfsf_pkg::POS_W-1:0]  top_row,
	input logic [lfsf_pkg::POS_W-1:0]  left_column
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(square_size)
			&& $stable(top_row) && $stable(left_column))
		else $error("result changed while stalled");

	// an empty map reports the origin
	a_empty_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && square_size == '0 |-> top_row == '0 && left_column == '0)
		else $error("size zero with nonzero corner");

	// a new result follows a cell transfer
	a_result_after_cell: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a preceding cell transfer");

endmodule

bind largest_free_square_finder lfsf_checker u_lfsf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.square_size (square_size),
	.top_row     (top_row),
	.left_column (left_column)
);

FILE: dv/free_square_checker.sv
// ----------------------------------------------------------------------------
// free_square_checker
// Watches the cell, result and register ports of the largest free square
// finder, tracks the square sizes of each map as it streams in, and compares
// every result transfer against the oldest square still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module free_square_checker import lfsf_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 cell_free,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [SIZE_W-1:0]    square_size,
	input  logic [POS_W-1:0]     top_row,
	input  logic [POS_W-1:0]     left_column,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending_results
);

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
	} square_t;

	logic [CFG_W-1:0]  rows_reg;
	logic [CFG_W-1:0]  cols_reg;
	logic [SIZE_W-1:0] line_sizes [MAX_COLUMNS];
	logic [SIZE_W-1:0] left_sz;
	logic [SIZE_W-1:0] corner_sz;
	logic [SIZE_W-1:0] best_sz;
	logic [POS_W-1:0]  cur_row;
	logic [POS_W-1:0]  cur_col;
	logic [POS_W-1:0]  best_r;
	logic [POS_W-1:0]  best_c;
	square_t           squares_due [$];
	square_t           due;

	// zero counts as one, anything past the limit clamps to it
	function automatic int effective_count(input logic [CFG_W-1:0] raw, input int limit);
		if (raw == '0)
			return 1;
		if (int'(raw) > limit)
			return limit;
		return int'(raw);
	endfunction

	task automatic clear_map();
		left_sz = '0;
		corner_sz = '0;
		cur_row = '0;
		cur_col = '0;
		best_sz = '0;
		best_r = '0;
		best_c = '0;
	endtask

	task automatic take_cell(input logic free);
		int                rows_eff;
		int                cols_eff;
		logic [SIZE_W-1:0] up;
		logic [SIZE_W-1:0] low;
		logic [SIZE_W-1:0] sz;
		square_t           sq;
		rows_eff = effective_count(rows_reg, MAX_ROWS);
		cols_eff = effective_count(cols_reg, MAX_COLUMNS);
		up = (cur_row != '0) ? line_sizes[cur_col] : '0;
		low = left_sz;
		if (up < low)
			low = up;
		if (corner_sz < low)
			low = corner_sz;
		if (!free)
			sz = '0;
		else if (cur_row == '0 || cur_col == '0)
			sz = SIZE_W'(1);
		else
			sz = low + 1'b1;
		line_sizes[cur_col] = sz;
		corner_sz = up;
		left_sz = sz;
		// strict compare: the first bottom-right corner keeps the lead on ties
		if (sz > best_sz) begin
			best_sz = sz;
			best_r = cur_row;
			best_c = cur_col;
		end
		if (int'(cur_col) + 1 < cols_eff) begin
			cur_col = cur_col + 1'b1;
		end else if (int'(cur_row) + 1 < rows_eff) begin
			cur_row = cur_row + 1'b1;
			cur_col = '0;
			left_sz = '0;
			corner_sz = '0;
		end else begin
			sq.size = best_sz;
			sq.row = (best_sz != '0) ? POS_W'(best_r - (best_sz - 1'b1)) : '0;
			sq.col = (best_sz != '0) ? POS_W'(best_c - (best_sz - 1'b1)) : '0;
			squares_due.push_back(sq);
			pending_results = pending_results + 1;
			clear_map();
		end
	endtask

	task automatic check_field(input string field, input int expected, input int actual);
		if (expected != actual) begin
			$error("%s mismatch: expected %0d, actual %0d", field, expected, actual);
			fail_count = fail_count + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg = COUNT_RESET;
			cols_reg = COUNT_RESET;
			for (int i = 0; i < MAX_COLUMNS; i++)
				line_sizes[i] = '0;
			clear_map();
			squares_due.delete();
			fail_count = 0;
			pending_results = 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					CFG_ROW_COUNT: rows_reg = cfg_data;
					CFG_COLUMN_COUNT: cols_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				take_cell(cell_free);
			if (out_valid && out_ready) begin
				if (squares_due.size() == 0) begin
					$error("result transfer with no square due: size %0d row %0d column %0d",
						square_size, top_row, left_column);
					fail_count = fail_count + 1;
				end else begin
					due = squares_due.pop_front();
					pending_results = pending_results - 1;
					check_field("square_size", int'(due.size), int'(square_size));
					check_field("top_row", int'(due.row), int'(top_row));
					check_field("left_column", int'(due.col), int'(left_column));
				end
			end
		end
	end

endmodule

FILE: dv/largest_free_square_finder_tb.sv
// ----------------------------------------------------------------------------
// largest_free_square_finder_tb
// Streams maps of free and obstacle cells into the finder with random idles
// on the cell side and random back-pressure on the result side, reshapes the
// map between maps, and lets the checker score every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module largest_free_square_finder_tb;
	import lfsf_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 2000;
	localparam int IDLE_PCT    = 23;
	localparam int SMALL_ITEMS = 850;
	localparam int MIN_MAPS    = 28;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 cell_free;
	logic                 out_valid;
	logic                 out_ready;
	logic [SIZE_W-1:0]    square_size;
	logic [POS_W-1:0]     top_row;
	logic [POS_W-1:0]     left_column;
	logic                 cfg_write_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   fail_count;
	int                   pending_results;
	int                   idle_pct = IDLE_PCT;
	int                   cycle_count = 0;
	bit                   hold_off_request = 1'b0;

	largest_free_square_finder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cell_free(cell_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.square_size(square_size),
		.top_row(top_row),
		.left_column(left_column),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	free_square_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cell_free(cell_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.square_size(square_size),
		.top_row(top_row),
		.left_column(left_column),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending_results(pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_request && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	task automatic send_cell(input logic free);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cell_free <= free;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// cells go out most significant bit first, row-major
	task automatic send_bits(input int count, input logic [31:0] bits);
		for (int i = count - 1; i >= 0; i--)
			send_cell(bits[i]);
	endtask

	task automatic send_map(input int rows, input int cols, input int free_pct);
		for (int n = 0; n < rows * cols; n++)
			send_cell($urandom_range(99) < free_pct);
	endtask

	// drop valid, wait for every result, then let the size stage drain
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_shape(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
		settle();
		cfg_write_en <= 1'b1;
		cfg_index <= CFG_ROW_COUNT;
		cfg_data <= rows;
		@(negedge clk);
		cfg_index <= CFG_COLUMN_COUNT;
		cfg_data <= cols;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	function automatic int pick_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 80)
			return $urandom_range(1, 6);
		if (roll < 97)
			return $urandom_range(7, 16);
		return $urandom_range(17, 24);
	endfunction

	initial begin
		int rows;
		int cols;
		int maps;
		int items;
		int free_pct;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cell_free = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = CFG_ROW_COUNT;
		cfg_data = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// single-cell maps: obstacle only, then free
		set_shape(11'd1, 11'd1);
		send_bits(2, 32'b01);
		// zero counts as one
		set_shape(11'd0, 11'd0);
		send_bits(1, 32'b1);
		// fully free map gives a square filling it
		set_shape(11'd3, 11'd3);
		send_bits(9, 32'h1ff);
		// two size-2 squares tie; the first one keeps the lead
		set_shape(11'd2, 11'd4);
		send_bits(8, 32'b0111_1111);
		// no free cell at all
		set_shape(11'd2, 11'd2);
		send_bits(4, 32'b0000);

		maps = 0;
		items = 0;
		rows = 1;
		cols = 1;
		while (items < SMALL_ITEMS || maps < MIN_MAPS) begin
			if (maps == 12)
				hold_off_request = 1'b1;
			if (maps == 24) begin
				// widest map via an over-range column count, with no idling
				set_shape(11'd1, 11'd2047);
				idle_pct = 0;
				send_map(1, MAX_COLUMNS_DEF, 97);
				idle_pct = IDLE_PCT;
			end
			if (maps % 8 == 0) begin
				rows = pick_size();
				cols = pick_size();
				set_shape((rows == 1 && $urandom_range(1)) ? '0 : CFG_W'(rows),
					(cols == 1 && $urandom_range(1)) ? '0 : CFG_W'(cols));
			end else if ((maps < 12 || maps > 13) && $urandom_range(7) == 0) begin
				// settle at random, but keep offering cells while the result side holds off
				settle();
			end
			case ($urandom_range(5))
				0: free_pct = 0;
				1: free_pct = 100;
				2: free_pct = 50;
				default: free_pct = $urandom_range(70, 95);
			endcase
			send_map(rows, cols, free_pct);
			items = items + rows * cols;
			maps = maps + 1;
		end

		settle();
		repeat (12) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
